FILE: hdl/lce_pkg.sv
// Shared constants, codes and types for the leader clustering engine.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package lce_pkg;

    localparam int MAX_CLUSTERS = 64;
    localparam int IDX_W        = $clog2(MAX_CLUSTERS);
    localparam int TOT_W        = $clog2(MAX_CLUSTERS + 1);
    localparam int COUNT_BITS   = 20;
    localparam int FRAC_BITS    = 8;
    localparam int COORD_W      = 16;
    localparam int CEN_W        = COORD_W + FRAC_BITS;
    localparam int SUM_W        = COORD_W + COUNT_BITS;
    localparam int DIVD_W       = SUM_W + FRAC_BITS;
    localparam int SQ_W         = 2 * CEN_W;
    localparam int DIST_W       = SQ_W + 1;
    localparam int RLIM_W       = 2 * COORD_W + 2 * FRAC_BITS;
    localparam int DLIM_W       = RLIM_W + 1;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd2;

    localparam logic [2:0] ST_JOINED     = 3'd0;
    localparam logic [2:0] ST_CREATED    = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL = 3'd2;
    localparam logic [2:0] ST_COUNT_FULL = 3'd3;
    localparam logic [2:0] ST_CLEARED    = 3'd4;
    localparam logic [2:0] ST_READ_OK    = 3'd5;
    localparam logic [2:0] ST_BAD_INDEX  = 3'd6;

    typedef struct packed {
        logic [SUM_W-1:0]      sum_x;
        logic [SUM_W-1:0]      sum_y;
        logic [COUNT_BITS-1:0] count;
        logic [CEN_W-1:0]      cen_x;
        logic [CEN_W-1:0]      cen_y;
    } entry_t;

    typedef struct packed {
        logic [2:0]            status;
        logic [IDX_W-1:0]      cluster_index;
        logic [COUNT_BITS-1:0] member_count;
        logic [CEN_W-1:0]      centroid_x;
        logic [CEN_W-1:0]      centroid_y;
        logic [TOT_W-1:0]      clusters_in_use;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/lce_if.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on lce_pkg for field widths.
`default_nettype none

interface lce_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      opcode;
    logic [lce_pkg::COORD_W-1:0]     point_x;
    logic [lce_pkg::COORD_W-1:0]     point_y;
    logic [lce_pkg::IDX_W-1:0]       entry_index;

    modport source (output valid, opcode, point_x, point_y, entry_index, input ready);
    modport sink   (input valid, opcode, point_x, point_y, entry_index, output ready);
endinterface

interface lce_out_if;
    logic                            valid;
    logic                            ready;
    logic [2:0]                      status;
    logic [lce_pkg::IDX_W-1:0]       cluster_index;
    logic [lce_pkg::COUNT_BITS-1:0]  member_count;
    logic [lce_pkg::CEN_W-1:0]       centroid_x;
    logic [lce_pkg::CEN_W-1:0]       centroid_y;
    logic [lce_pkg::TOT_W-1:0]       clusters_in_use;

    modport source (output valid, status, cluster_index, member_count, centroid_x,
                    centroid_y, clusters_in_use, input ready);
    modport sink   (input valid, status, cluster_index, member_count, centroid_x,
                    centroid_y, clusters_in_use, output ready);
endinterface

`default_nettype wire

FILE: hdl/lce_div.sv
// Restoring divider, one quotient bit per cycle, for centroid updates.
// Depends on lce_pkg for operand widths.
`default_nettype none

module lce_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [lce_pkg::DIVD_W-1:0]       dividend,
    input  wire logic [lce_pkg::COUNT_BITS-1:0]   divisor,
    output logic                                  done,
    output logic [lce_pkg::CEN_W-1:0]             quotient
);

    localparam int CNT_W = $clog2(lce_pkg::DIVD_W + 1);

    logic                              busy_reg;
    logic                              done_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [lce_pkg::COUNT_BITS-1:0]    rem_reg;
    logic [lce_pkg::COUNT_BITS-1:0]    rem_next;
    logic [lce_pkg::DIVD_W-1:0]        quo_reg;
    logic [lce_pkg::COUNT_BITS-1:0]    den_reg;
    logic [lce_pkg::COUNT_BITS:0]      rem_sh;
    logic [lce_pkg::COUNT_BITS:0]      rem_diff;
    logic                              ge;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[lce_pkg::DIVD_W-1]};
        rem_diff = rem_sh - {1'b0, den_reg};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? rem_diff[lce_pkg::COUNT_BITS-1:0]
                      : rem_sh[lce_pkg::COUNT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(lce_pkg::DIVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[lce_pkg::DIVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[lce_pkg::CEN_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/leader_clustering_engine.sv
// Leader clustering engine: add/clear/read over a 64-entry cluster memory.
// Add: scan of N stored centroids through a 3-stage distance pipe, then a re-read and,
// unless the count is full, a divide on a join. One item at a time; the result register
// lets the next item enter while a result waits. Reset empties the table at once.
// Depends on lce_pkg, lce_if and lce_div.
`default_nettype none

module leader_clustering_engine (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    lce_in_if.sink                                 item_in,
    lce_out_if.source                              result_out,
    input  wire logic                              cfg_we,
    input  wire logic [lce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lce_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_JUDGE = 3'd2;
    localparam logic [2:0] S_JREAD = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_RREAD = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    localparam int IW = lce_pkg::IDX_W;
    localparam int TW = lce_pkg::TOT_W;

    logic [2:0]                        state_reg, state_next;
    logic [TW-1:0]                     total_reg, total_next;
    logic [lce_pkg::COORD_W-1:0]       radius_reg, width_reg, height_reg;
    logic [lce_pkg::COORD_W-1:0]       px_reg, py_reg;
    logic [IW-1:0]                     ei_reg;
    logic [lce_pkg::RLIM_W-1:0]        rlim_reg;
    logic [lce_pkg::DLIM_W-1:0]        dlim_reg;

    logic [TW-1:0]                     issue_reg;
    logic                              p0_vld_reg, s1_vld_reg, s2_vld_reg;
    logic [IW-1:0]                     p0_idx_reg, s1_idx_reg, s2_idx_reg;
    logic [lce_pkg::CEN_W-1:0]         dx_reg, dy_reg;
    logic [lce_pkg::SQ_W-1:0]          sqx_reg, sqy_reg;
    logic                              found_reg;
    logic [lce_pkg::DIST_W-1:0]        best_d_reg;
    logic [IW-1:0]                     best_idx_reg;

    lce_pkg::entry_t                   mem [lce_pkg::MAX_CLUSTERS];
    lce_pkg::entry_t                   rd_q;
    lce_pkg::entry_t                   wr_data;
    lce_pkg::entry_t                   upd_reg;
    logic [IW-1:0]                     rd_addr, wr_addr;
    logic                              wr_en;

    lce_pkg::result_t                  res_reg, res_next;
    lce_pkg::result_t                  out_reg;
    logic                              out_vld_reg;

    logic                              accept;
    logic [lce_pkg::CEN_W-1:0]         qx, qy;
    logic [lce_pkg::DIST_W-1:0]        dist_sum;
    logic                              join_ok;
    logic                              div_start, div_done, div_done_y;
    logic [lce_pkg::CEN_W-1:0]         quo_x, quo_y;
    logic [lce_pkg::COUNT_BITS-1:0]    cnt_inc;
    logic [lce_pkg::SUM_W-1:0]         sumx_inc, sumy_inc;

    assign accept         = item_in.valid && item_in.ready;
    assign item_in.ready  = (state_reg == S_IDLE);
    assign qx             = {px_reg, {lce_pkg::FRAC_BITS{1'b0}}};
    assign qy             = {py_reg, {lce_pkg::FRAC_BITS{1'b0}}};
    assign dist_sum       = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign join_ok        = found_reg && (best_d_reg < {1'b0, rlim_reg})
                            && (best_d_reg < dlim_reg);
    assign cnt_inc        = rd_q.count + lce_pkg::COUNT_BITS'(1);
    assign sumx_inc       = rd_q.sum_x + lce_pkg::SUM_W'(px_reg);
    assign sumy_inc       = rd_q.sum_y + lce_pkg::SUM_W'(py_reg);

    lce_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sumx_inc, {lce_pkg::FRAC_BITS{1'b0}}}),
        .divisor  (cnt_inc),
        .done     (div_done),
        .quotient (quo_x)
    );

    lce_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sumy_inc, {lce_pkg::FRAC_BITS{1'b0}}}),
        .divisor  (cnt_inc),
        .done     (div_done_y),
        .quotient (quo_y)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        res_next   = res_reg;
        rd_addr    = issue_reg[IW-1:0];
        wr_en      = 1'b0;
        wr_addr    = best_idx_reg;
        wr_data    = upd_reg;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                rd_addr = item_in.entry_index;
                if (accept)
                begin
                    if (item_in.opcode == lce_pkg::OP_CLEAR)
                    begin
                        total_next = '0;
                        res_next   = '0;
                        res_next.status = lce_pkg::ST_CLEARED;
                        state_next = S_FIN;
                    end
                    else if (item_in.opcode == lce_pkg::OP_ADD)
                        state_next = S_SCAN;
                    else
                        state_next = S_RREAD;
                end
            end
            S_SCAN:
            begin
                if (issue_reg == total_reg && !p0_vld_reg && !s1_vld_reg && !s2_vld_reg)
                    state_next = S_JUDGE;
            end
            S_JUDGE:
            begin
                rd_addr  = best_idx_reg;
                res_next = '0;
                res_next.clusters_in_use = total_reg;
                if (join_ok)
                    state_next = S_JREAD;
                else if (total_reg == TW'(lce_pkg::MAX_CLUSTERS))
                begin
                    res_next.status = lce_pkg::ST_TABLE_FULL;
                    state_next      = S_FIN;
                end
                else
                begin
                    wr_en         = 1'b1;
                    wr_addr       = total_reg[IW-1:0];
                    wr_data.sum_x = lce_pkg::SUM_W'(px_reg);
                    wr_data.sum_y = lce_pkg::SUM_W'(py_reg);
                    wr_data.count = lce_pkg::COUNT_BITS'(1);
                    wr_data.cen_x = qx;
                    wr_data.cen_y = qy;
                    total_next    = total_reg + TW'(1);
                    res_next.status          = lce_pkg::ST_CREATED;
                    res_next.cluster_index   = total_reg[IW-1:0];
                    res_next.member_count    = lce_pkg::COUNT_BITS'(1);
                    res_next.centroid_x      = qx;
                    res_next.centroid_y      = qy;
                    res_next.clusters_in_use = total_reg + TW'(1);
                    state_next = S_FIN;
                end
            end
            S_JREAD:
            begin
                res_next.cluster_index = best_idx_reg;
                if (rd_q.count == lce_pkg::COUNT_MAX)
                begin
                    res_next.status       = lce_pkg::ST_COUNT_FULL;
                    res_next.member_count = rd_q.count;
                    res_next.centroid_x   = rd_q.cen_x;
                    res_next.centroid_y   = rd_q.cen_y;
                    state_next = S_FIN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    wr_en         = 1'b1;
                    wr_data.cen_x = quo_x;
                    wr_data.cen_y = quo_y;
                    res_next.status       = lce_pkg::ST_JOINED;
                    res_next.member_count = upd_reg.count;
                    res_next.centroid_x   = quo_x;
                    res_next.centroid_y   = quo_y;
                    state_next = S_FIN;
                end
            end
            S_RREAD:
            begin
                res_next = '0;
                res_next.clusters_in_use = total_reg;
                if (TW'(ei_reg) < total_reg)
                begin
                    res_next.status        = lce_pkg::ST_READ_OK;
                    res_next.cluster_index = ei_reg;
                    res_next.member_count  = rd_q.count;
                    res_next.centroid_x    = rd_q.cen_x;
                    res_next.centroid_y    = rd_q.cen_y;
                end
                else
                    res_next.status = lce_pkg::ST_BAD_INDEX;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_vld_reg || result_out.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            radius_reg  <= lce_pkg::COORD_W'(1024);
            width_reg   <= '1;
            height_reg  <= '1;
            out_vld_reg <= 1'b0;
            p0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            issue_reg   <= '0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    lce_pkg::CFG_RADIUS:     radius_reg <= cfg_data;
                    lce_pkg::CFG_MAP_WIDTH:  width_reg  <= cfg_data;
                    lce_pkg::CFG_MAP_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_FIN && state_next == S_IDLE)
                out_vld_reg <= 1'b1;
            else if (result_out.ready)
                out_vld_reg <= 1'b0;

            p0_vld_reg <= (state_reg == S_SCAN) && (issue_reg != total_reg);
            s1_vld_reg <= p0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            if (accept)
            begin
                issue_reg <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (state_reg == S_SCAN && issue_reg != total_reg)
                    issue_reg <= issue_reg + TW'(1);
                if (s2_vld_reg)
                    found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg   <= item_in.point_x;
            py_reg   <= item_in.point_y;
            ei_reg   <= item_in.entry_index;
            rlim_reg <= {({{lce_pkg::COORD_W{1'b0}}, radius_reg}
                          * {{lce_pkg::COORD_W{1'b0}}, radius_reg}),
                         {2 * lce_pkg::FRAC_BITS{1'b0}}};
            dlim_reg <= {({{(lce_pkg::COORD_W+1){1'b0}}, width_reg}
                          * {{(lce_pkg::COORD_W+1){1'b0}}, width_reg}
                          + {{(lce_pkg::COORD_W+1){1'b0}}, height_reg}
                          * {{(lce_pkg::COORD_W+1){1'b0}}, height_reg}),
                         {2 * lce_pkg::FRAC_BITS{1'b0}}};
        end
        p0_idx_reg <= issue_reg[IW-1:0];
        s1_idx_reg <= p0_idx_reg;
        dx_reg     <= (qx > rd_q.cen_x) ? qx - rd_q.cen_x : rd_q.cen_x - qx;
        dy_reg     <= (qy > rd_q.cen_y) ? qy - rd_q.cen_y : rd_q.cen_y - qy;
        s2_idx_reg <= s1_idx_reg;
        sqx_reg    <= dx_reg * dx_reg;
        sqy_reg    <= dy_reg * dy_reg;
        if (s2_vld_reg && (!found_reg || dist_sum < best_d_reg))
        begin
            best_d_reg   <= dist_sum;
            best_idx_reg <= s2_idx_reg;
        end
        if (state_reg == S_JREAD)
        begin
            upd_reg.sum_x <= sumx_inc;
            upd_reg.sum_y <= sumy_inc;
            upd_reg.count <= cnt_inc;
            upd_reg.cen_x <= '0;
            upd_reg.cen_y <= '0;
        end
        res_reg <= res_next;
        if (state_reg == S_FIN && state_next == S_IDLE)
            out_reg <= res_reg;
    end

    assign result_out.valid           = out_vld_reg;
    assign result_out.status          = out_reg.status;
    assign result_out.cluster_index   = out_reg.cluster_index;
    assign result_out.member_count    = out_reg.member_count;
    assign result_out.centroid_x      = out_reg.centroid_x;
    assign result_out.centroid_y      = out_reg.centroid_y;
    assign result_out.clusters_in_use = out_reg.clusters_in_use;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TW'(lce_pkg::MAX_CLUSTERS))
        else $error("cluster total beyond table size");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item_in.opcode == lce_pkg::OP_CLEAR |=> total_reg == '0)
        else $error("clear left clusters in use");

    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> state_reg == S_SCAN)
        else $error("distance pipe active outside scan");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside update");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div_done == div_done_y)
        else $error("dividers out of step");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for leader_clustering_engine: directed and random add/clear/read
// beats with a built-in cluster table predictor and random stalls on both channels.
// Depends on lce_pkg, lce_if and the engine RTL.
`timescale 1ns / 100ps

module testbench;

    localparam logic [1:0] OP_READ      = 2'd2;
    localparam logic [1:0] OP_READ_ALT  = 2'd3;
    localparam int         CYCLE_LIMIT  = 2000000;
    localparam int         SETTLE       = 120;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [lce_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lce_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    lce_in_if  item_if();
    lce_out_if res_if();

    leader_clustering_engine dut (
        .clk(clk), .rst_n(rst_n), .item_in(item_if), .result_out(res_if),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // predictor state
    logic [15:0]                    radius_q, map_w_q, map_h_q;
    int unsigned                    live_clusters;
    logic [lce_pkg::SUM_W-1:0]      sum_x_q [lce_pkg::MAX_CLUSTERS];
    logic [lce_pkg::SUM_W-1:0]      sum_y_q [lce_pkg::MAX_CLUSTERS];
    logic [lce_pkg::COUNT_BITS-1:0] members_q [lce_pkg::MAX_CLUSTERS];
    logic [lce_pkg::CEN_W-1:0]      cen_x_q [lce_pkg::MAX_CLUSTERS];
    logic [lce_pkg::CEN_W-1:0]      cen_y_q [lce_pkg::MAX_CLUSTERS];

    lce_pkg::result_t pending_results[$];
    int               send_idle = 0;
    int               recv_idle = 0;
    int               mismatches = 0;
    int               results_seen = 0;
    int               status_hits[8];
    int unsigned      cycles = 0;

    function automatic lce_pkg::result_t entry_report(logic [2:0] st, int idx, bit with_entry);
        lce_pkg::result_t r;
        r = '0;
        r.status = st;
        if (with_entry)
        begin
            r.cluster_index = idx[lce_pkg::IDX_W-1:0];
            r.member_count  = members_q[idx];
            r.centroid_x    = cen_x_q[idx];
            r.centroid_y    = cen_y_q[idx];
        end
        r.clusters_in_use = live_clusters[lce_pkg::TOT_W-1:0];
        return r;
    endfunction

    function automatic lce_pkg::result_t cluster_step(logic [1:0] op, logic [15:0] px,
                                                      logic [15:0] py,
                                                      logic [lce_pkg::IDX_W-1:0] ei);
        logic [63:0] qx, qy, dx, dy, d, best_d, rlim, dlim;
        int          best;
        bit          found;
        best = 0;
        found = 0;
        best_d = '0;
        if (op == lce_pkg::OP_CLEAR)
        begin
            live_clusters = 0;
            return entry_report(lce_pkg::ST_CLEARED, 0, 0);
        end
        if (op == OP_READ || op == OP_READ_ALT)
        begin
            if (ei < live_clusters)
                return entry_report(lce_pkg::ST_READ_OK, ei, 1);
            return entry_report(lce_pkg::ST_BAD_INDEX, 0, 0);
        end
        qx = {40'd0, px, 8'd0};
        qy = {40'd0, py, 8'd0};
        rlim = (64'(radius_q) * 64'(radius_q)) << 16;
        dlim = (64'(map_w_q) * 64'(map_w_q) + 64'(map_h_q) * 64'(map_h_q)) << 16;
        for (int i = 0; i < live_clusters; i++)
        begin
            dx = (qx > cen_x_q[i]) ? qx - cen_x_q[i] : cen_x_q[i] - qx;
            dy = (qy > cen_y_q[i]) ? qy - cen_y_q[i] : cen_y_q[i] - qy;
            d = dx * dx + dy * dy;
            if (!found || d < best_d)
            begin
                found = 1;
                best_d = d;
                best = i;
            end
        end
        if (found && best_d < rlim && best_d < dlim)
        begin
            if (members_q[best] == lce_pkg::COUNT_MAX)
                return entry_report(lce_pkg::ST_COUNT_FULL, best, 1);
            members_q[best] = members_q[best] + 1'b1;
            sum_x_q[best] = sum_x_q[best] + px;
            sum_y_q[best] = sum_y_q[best] + py;
            cen_x_q[best] = lce_pkg::CEN_W'((64'(sum_x_q[best]) << lce_pkg::FRAC_BITS)
                                            / members_q[best]);
            cen_y_q[best] = lce_pkg::CEN_W'((64'(sum_y_q[best]) << lce_pkg::FRAC_BITS)
                                            / members_q[best]);
            return entry_report(lce_pkg::ST_JOINED, best, 1);
        end
        if (live_clusters >= lce_pkg::MAX_CLUSTERS)
            return entry_report(lce_pkg::ST_TABLE_FULL, 0, 0);
        sum_x_q[live_clusters]   = lce_pkg::SUM_W'(px);
        sum_y_q[live_clusters]   = lce_pkg::SUM_W'(py);
        members_q[live_clusters] = 1;
        cen_x_q[live_clusters]   = qx[lce_pkg::CEN_W-1:0];
        cen_y_q[live_clusters]   = qy[lce_pkg::CEN_W-1:0];
        live_clusters++;
        return entry_report(lce_pkg::ST_CREATED, live_clusters - 1, 1);
    endfunction

    function automatic void add_prediction(lce_pkg::result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // result side: random back-pressure, compare each beat with the oldest prediction
    always @(negedge clk)
        res_if.ready = ($urandom_range(0, 99) >= recv_idle);

    always @(posedge clk)
    begin
        lce_pkg::result_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with no prediction waiting, status %0d", res_if.status);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                status_hits[want.status]++;
                if (res_if.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res_if.status);
                    mismatches++;
                end
                if (res_if.cluster_index !== want.cluster_index)
                begin
                    $error("cluster_index: expected %0d, got %0d",
                           want.cluster_index, res_if.cluster_index);
                    mismatches++;
                end
                if (res_if.member_count !== want.member_count)
                begin
                    $error("member_count: expected %0d, got %0d",
                           want.member_count, res_if.member_count);
                    mismatches++;
                end
                if (res_if.centroid_x !== want.centroid_x)
                begin
                    $error("centroid_x: expected %0h, got %0h",
                           want.centroid_x, res_if.centroid_x);
                    mismatches++;
                end
                if (res_if.centroid_y !== want.centroid_y)
                begin
                    $error("centroid_y: expected %0h, got %0h",
                           want.centroid_y, res_if.centroid_y);
                    mismatches++;
                end
                if (res_if.clusters_in_use !== want.clusters_in_use)
                begin
                    $error("clusters_in_use: expected %0d, got %0d",
                           want.clusters_in_use, res_if.clusters_in_use);
                    mismatches++;
                end
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_beat(logic [1:0] op, logic [15:0] px, logic [15:0] py,
                             logic [lce_pkg::IDX_W-1:0] ei);
        while ($urandom_range(0, 99) < send_idle)
        begin
            item_if.valid = 1'b0;
            @(negedge clk);
        end
        item_if.valid       = 1'b1;
        item_if.opcode      = op;
        item_if.point_x     = px;
        item_if.point_y     = py;
        item_if.entry_index = ei;
        do @(posedge clk); while (!item_if.ready);
        add_prediction(cluster_step(op, px, py, ei));
        @(negedge clk);
        item_if.valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [lce_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
        drain();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            lce_pkg::CFG_RADIUS:    radius_q = value;
            lce_pkg::CFG_MAP_WIDTH: map_w_q  = value;
            default:                map_h_q  = value;
        endcase
    endtask

    task automatic set_limits(logic [15:0] r, logic [15:0] w, logic [15:0] h);
        write_reg(lce_pkg::CFG_RADIUS, r);
        write_reg(lce_pkg::CFG_MAP_WIDTH, w);
        write_reg(lce_pkg::CFG_MAP_HEIGHT, h);
    endtask

    task automatic test_directed();
        send_beat(OP_READ, 16'h0000, 16'h0000, 6'd0);
        send_beat(lce_pkg::OP_ADD, 16'd1000, 16'd1000, 6'd0);
        send_beat(lce_pkg::OP_ADD, 16'd1003, 16'd1001, 6'd0);
        send_beat(lce_pkg::OP_ADD, 16'd1000, 16'd1004, 6'd0);
        send_beat(lce_pkg::OP_ADD, 16'd5000, 16'd5000, 6'd0);
        send_beat(lce_pkg::OP_ADD, 16'd3000, 16'd3000, 6'd0);
        send_beat(lce_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 6'd0);
        send_beat(lce_pkg::OP_ADD, 16'hFFFE, 16'hFFFF, 6'd0);
        send_beat(lce_pkg::OP_ADD, 16'h0000, 16'hFFFF, 6'd0);
        send_beat(lce_pkg::OP_ADD, 16'hFFFF, 16'h0000, 6'd0);
        send_beat(OP_READ, 16'hFFFF, 16'hFFFF, 6'd1);
        send_beat(OP_READ_ALT, 16'h0000, 16'h0000, 6'd2);
        send_beat(OP_READ, 16'h0000, 16'h0000, 6'd63);
        send_beat(OP_READ, 16'h0000, 16'h0000, 6'd7);
        set_limits(16'd0, 16'hFFFF, 16'hFFFF);
        send_beat(lce_pkg::OP_ADD, 16'd1000, 16'd1000, 6'd0);
        set_limits(16'hFFFF, 16'd0, 16'd0);
        send_beat(lce_pkg::OP_ADD, 16'd1000, 16'd1000, 6'd0);
        set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(lce_pkg::OP_ADD, 16'd0, 16'd0, 6'd0);
        send_beat(lce_pkg::OP_ADD, 16'd2, 16'd2, 6'd0);
        send_beat(lce_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 6'h3F);
        send_beat(OP_READ, 16'h0000, 16'h0000, 6'd0);
    endtask

    task automatic test_table_full();
        set_limits(16'd0, 16'hFFFF, 16'hFFFF);
        send_beat(lce_pkg::OP_CLEAR, 16'd0, 16'd0, 6'd0);
        for (int i = 0; i < lce_pkg::MAX_CLUSTERS + 3; i++)
            send_beat(lce_pkg::OP_ADD, 16'($urandom), 16'($urandom), 6'($urandom));
        send_beat(OP_READ, 16'd0, 16'd0, 6'd63);
        set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(lce_pkg::OP_ADD, 16'($urandom), 16'($urandom), 6'd0);
        send_beat(lce_pkg::OP_CLEAR, 16'd0, 16'd0, 6'd0);
    endtask

    task automatic test_random(int beats);
        logic [15:0] hub_x[8], hub_y[8];
        int          k, ox, oy, pick;
        for (int h = 0; h < 8; h++)
        begin
            hub_x[h] = 16'($urandom);
            hub_y[h] = 16'($urandom);
        end
        for (int n = 0; n < beats; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                send_beat(lce_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 6'($urandom));
            end
            else if (pick < 18)
            begin
                send_beat(2'($urandom_range(2, 3)), 16'($urandom), 16'($urandom),
                          6'($urandom));
            end
            else if (pick < 28)
            begin
                send_beat(lce_pkg::OP_ADD, 16'($urandom), 16'($urandom), 6'($urandom));
            end
            else
            begin
                k  = $urandom_range(0, 7);
                ox = int'(hub_x[k]) + $urandom_range(0, 1200) - 600;
                oy = int'(hub_y[k]) + $urandom_range(0, 1200) - 600;
                ox = ox < 0 ? 0 : (ox > 65535 ? 65535 : ox);
                oy = oy < 0 ? 0 : (oy > 65535 ? 65535 : oy);
                send_beat(lce_pkg::OP_ADD, 16'(ox), 16'(oy), 6'($urandom));
            end
        end
    endtask

    task automatic test_random_phases();
        send_idle = 26; recv_idle = 49;
        set_limits(16'd800, 16'hFFFF, 16'hFFFF);
        test_random(250);
        // hold off until the engine has caught up
        drain();
        send_idle = 49; recv_idle = 26;
        set_limits(16'($urandom_range(100, 3000)), 16'($urandom_range(0, 2000)),
                   16'($urandom));
        test_random(250);
        send_idle = 0; recv_idle = 0;
        set_limits(16'hFFFF, 16'($urandom), 16'($urandom));
        test_random(150);
        set_limits(16'($urandom_range(1, 600)), 16'hFFFF, 16'd0);
        test_random(100);
    endtask

    initial
    begin
        item_if.valid = 1'b0;
        item_if.opcode = lce_pkg::OP_ADD;
        item_if.point_x = '0;
        item_if.point_y = '0;
        item_if.entry_index = '0;
        res_if.ready = 1'b0;
        radius_q = 16'd1024;
        map_w_q = 16'hFFFF;
        map_h_q = 16'hFFFF;
        live_clusters = 0;
        send_idle = 26;
        recv_idle = 49;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_table_full();
        test_random_phases();
        while (pending_results.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        $display("covered %0d result beats: joined %0d, created %0d, table full %0d,",
                 results_seen, status_hits[lce_pkg::ST_JOINED],
                 status_hits[lce_pkg::ST_CREATED], status_hits[lce_pkg::ST_TABLE_FULL]);
        $display("  cleared %0d, read ok %0d, bad index %0d; %0d field mismatches",
                 status_hits[lce_pkg::ST_CLEARED], status_hits[lce_pkg::ST_READ_OK],
                 status_hits[lce_pkg::ST_BAD_INDEX], mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
